>>> sv/smp_pkg.sv
// Shared constants and types for the STUN mapped-port parser.
package smp_pkg;

    localparam int unsigned SMP_MAX_PACKET_BYTES = 2048;

    localparam int unsigned HEADER_BYTES = 20;
    localparam logic [15:0] TYPE_PLAIN = 16'h0001;
    localparam logic [15:0] TYPE_XOR = 16'h0020;
    localparam logic [15:0] PORT_XOR_MASK = 16'h2112;
    localparam logic [15:0] MIN_ATTR_LEN = 16'd8;

    typedef struct packed {
        logic        port_found;
        logic [15:0] mapped_port;
        logic        from_xor_attribute;
    } smp_result_t;

endpackage

>>> sv/smp_byte_if.sv
// Byte channel into the parser: one payload byte with a last-byte mark per item.
interface smp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/smp_result_if.sv
// Result channel out of the parser: one item per packet.
interface smp_result_if;
    logic        valid;
    logic        ready;
    logic        port_found;
    logic [15:0] mapped_port;
    logic        from_xor_attribute;

    modport source (output valid, output port_found, output mapped_port,
                    output from_xor_attribute, input ready);
    modport sink (input valid, input port_found, input mapped_port,
                  input from_xor_attribute, output ready);
endinterface

>>> sv/smp_core.sv
// Attribute walker: per-byte state update and result of the packet in flight.
module smp_core
    import smp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = SMP_MAX_PACKET_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output smp_result_t packet_result
);

    localparam int unsigned OFS_W = $clog2(MAX_PACKET_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ATTR_HDR,
        PH_VALUE,
        PH_PAD,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [OFS_W-1:0]   offset_reg, offset_next;
    logic [1:0]         field_cnt_reg, field_cnt_next;
    logic [15:0]        type_word_reg, type_word_next;
    logic [15:0]        attr_len_reg, attr_len_next;
    logic [15:0]        left_reg, left_next;
    logic [15:0]        cand_reg, cand_next;
    logic               hit_valid_reg, hit_valid_next;
    logic [15:0]        hit_port_reg, hit_port_next;
    logic               hit_xor_reg, hit_xor_next;

    logic [15:0] value_idx;
    logic [15:0] left_dec;
    logic [15:0] len_full;
    logic        attr_ends_aligned;
    logic        type_match;

    assign value_idx         = attr_len_reg - left_reg;
    assign left_dec          = left_reg - 16'd1;
    assign len_full          = {attr_len_reg[15:8], data_byte};
    assign attr_ends_aligned = (offset_reg[1:0] == 2'b11);
    assign type_match        = (type_word_reg == TYPE_PLAIN) || (type_word_reg == TYPE_XOR);

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        field_cnt_next = field_cnt_reg;
        type_word_next = type_word_reg;
        attr_len_next  = attr_len_reg;
        left_next      = left_reg;
        cand_next      = cand_reg;
        hit_valid_next = hit_valid_reg;
        hit_port_next  = hit_port_reg;
        hit_xor_next   = hit_xor_reg;

        if (offset_reg < OFS_W'(MAX_PACKET_BYTES))
        begin
            offset_next = offset_reg + OFS_W'(1);
            case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg >= OFS_W'(HEADER_BYTES - 1))
                    begin
                        phase_next     = PH_ATTR_HDR;
                        field_cnt_next = 2'd0;
                    end
                end
                PH_ATTR_HDR:
                begin
                    case (field_cnt_reg)
                        2'd0: type_word_next = {data_byte, 8'h00};
                        2'd1: type_word_next = {type_word_reg[15:8], data_byte};
                        2'd2: attr_len_next  = {data_byte, 8'h00};
                        default:
                        begin
                            attr_len_next = len_full;
                            left_next     = len_full;
                            cand_next     = 16'h0000;
                            if (len_full == 16'h0000)
                                phase_next = attr_ends_aligned ? PH_ATTR_HDR : PH_PAD;
                            else
                                phase_next = PH_VALUE;
                        end
                    endcase
                    field_cnt_next = field_cnt_reg + 2'd1;
                end
                PH_VALUE:
                begin
                    if (value_idx == 16'd2)
                        cand_next = {data_byte, cand_reg[7:0]};
                    else if (value_idx == 16'd3)
                        cand_next = {cand_reg[15:8], data_byte};
                    left_next = left_dec;
                    if (left_dec == 16'h0000)
                    begin
                        if (type_match && (attr_len_reg >= MIN_ATTR_LEN))
                        begin
                            hit_valid_next = 1'b1;
                            hit_xor_next   = (type_word_reg == TYPE_XOR);
                            hit_port_next  = (type_word_reg == TYPE_XOR) ?
                                             (cand_next ^ PORT_XOR_MASK) : cand_next;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            phase_next = attr_ends_aligned ? PH_ATTR_HDR : PH_PAD;
                        end
                    end
                end
                PH_PAD:
                begin
                    if (attr_ends_aligned)
                        phase_next = PH_ATTR_HDR;
                end
                default:
                begin
                end
            endcase
        end

        packet_result.port_found         = hit_valid_next;
        packet_result.mapped_port        = hit_valid_next ? hit_port_next : 16'h0000;
        packet_result.from_xor_attribute = hit_valid_next & hit_xor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            offset_reg    <= '0;
            field_cnt_reg <= '0;
            type_word_reg <= '0;
            attr_len_reg  <= '0;
            left_reg      <= '0;
            cand_reg      <= '0;
            hit_valid_reg <= 1'b0;
            hit_port_reg  <= '0;
            hit_xor_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg     <= PH_HEADER;
                offset_reg    <= '0;
                field_cnt_reg <= '0;
                type_word_reg <= '0;
                attr_len_reg  <= '0;
                left_reg      <= '0;
                cand_reg      <= '0;
                hit_valid_reg <= 1'b0;
                hit_port_reg  <= '0;
                hit_xor_reg   <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                offset_reg    <= offset_next;
                field_cnt_reg <= field_cnt_next;
                type_word_reg <= type_word_next;
                attr_len_reg  <= attr_len_next;
                left_reg      <= left_next;
                cand_reg      <= cand_next;
                hit_valid_reg <= hit_valid_next;
                hit_port_reg  <= hit_port_next;
                hit_xor_reg   <= hit_xor_next;
            end
        end
    end

    a_done_means_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) == hit_valid_reg)
        else $error("done phase and committed hit disagree");

    a_offset_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFS_W'(MAX_PACKET_BYTES))
        else $error("byte offset beyond packet limit");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> (offset_reg == '0) && (phase_reg == PH_HEADER)
                                && !hit_valid_reg)
        else $error("state not cleared after final byte");

endmodule

>>> sv/stun_mapped_port_parser.sv
// STUN mapped-port parser: takes a response byte per item, gives one result per packet.
// Accepts one payload byte per clock. A byte goes through an input register, the
// attribute walker updates its state from it in the next cycle, and on the byte marked
// last the port result is loaded into the output register, so the result item becomes
// valid when the final byte leaves the input register. Input stalls only when a final
// byte meets an output register whose earlier result has not yet been taken.
module stun_mapped_port_parser
    import smp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = SMP_MAX_PACKET_BYTES
)
(
    input  logic          clk,
    input  logic          rst_n,
    smp_byte_if.sink      rx,
    smp_result_if.source  result
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_vld_reg;
    smp_result_t out_data_reg;
    smp_result_t core_result;
    logic        advance;

    assign advance  = in_vld_reg && (!in_last_reg || !out_vld_reg || result.ready);
    assign rx.ready = !in_vld_reg || advance;

    smp_core #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .last_byte     (in_last_reg),
        .packet_result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance && in_last_reg)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.data_byte;
            in_last_reg <= rx.last_byte;
        end
        if (advance && in_last_reg)
            out_data_reg <= core_result;
    end

    assign result.valid              = out_vld_reg;
    assign result.port_found         = out_data_reg.port_found;
    assign result.mapped_port        = out_data_reg.mapped_port;
    assign result.from_xor_attribute = out_data_reg.from_xor_attribute;

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !$past(out_vld_reg)) |-> $past(advance && in_last_reg))
        else $error("result item without a final byte");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> rx.ready)
        else $error("empty input stage refuses items");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |-> (in_last_reg && out_vld_reg && !result.ready))
        else $error("input stage stalled without a blocked result");

    a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_data_reg.port_found) |->
        (out_data_reg.mapped_port == 16'h0000) && !out_data_reg.from_xor_attribute)
        else $error("result fields set without a found port");

endmodule
